// ----- hdl/u2cal_pkg.sv -----
// ----------------------------------------------------------------------------
// u2cal_pkg: shared types and constants of the epoch to calendar converter
// Microcode word layout, step addresses, opcodes, jump conditions, the
// control store and the month length table.
// ----------------------------------------------------------------------------
`default_nettype none

package u2cal_pkg;

  typedef logic [3:0] pc_t;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_LOAD,
    OP_DIV,
    OP_SAVE_SEC,
    OP_SAVE_MIN,
    OP_SAVE_HR,
    OP_YEAR,
    OP_MONTH,
    OP_EMIT
  } op_t;

  typedef enum logic [2:0] {
    C_NEXT,
    C_ALWAYS,
    C_NO_INPUT,
    C_YEAR_MORE,
    C_MONTH_MORE,
    C_OUT_BUSY
  } cond_t;

  typedef struct packed {
    logic        accept;
    op_t         op;
    cond_t       cond;
    logic [5:0]  divisor;
    pc_t         target;
  } ucw_t;

  // Step addresses of the control program.
  localparam pc_t S_LOAD     = 4'd0;
  localparam pc_t S_DIV_SEC  = 4'd1;
  localparam pc_t S_SAVE_SEC = 4'd2;
  localparam pc_t S_DIV_MIN  = 4'd3;
  localparam pc_t S_SAVE_MIN = 4'd4;
  localparam pc_t S_DIV_HR   = 4'd5;
  localparam pc_t S_SAVE_HR  = 4'd6;
  localparam pc_t S_YEAR     = 4'd7;
  localparam pc_t S_MONTH    = 4'd8;
  localparam pc_t S_EMIT     = 4'd9;
  localparam pc_t S_WRAP     = 4'd10;

  localparam logic [5:0]  SEC_PER_MIN  = 6'd60;
  localparam logic [5:0]  HR_PER_DAY   = 6'd24;
  // Reciprocals for exact division of any 32-bit value: x / 60 is
  // (x * RECIP_MIN) >> 37 and x / 24 is (x * RECIP_HR) >> 36.
  localparam logic [31:0] RECIP_MIN    = 32'h8888_8889;
  localparam logic [31:0] RECIP_HR     = 32'hAAAA_AAAB;
  localparam logic [11:0] EPOCH_YEAR   = 12'd1970;
  localparam logic [1:0]  EPOCH_MOD4   = 2'd2;
  localparam logic [6:0]  EPOCH_MOD100 = 7'd70;
  localparam logic [8:0]  EPOCH_MOD400 = 9'd370;
  localparam logic [6:0]  MOD100_LAST  = 7'd99;
  localparam logic [8:0]  MOD400_LAST  = 9'd399;
  localparam logic [8:0]  DAYS_LEAP    = 9'd366;
  localparam logic [8:0]  DAYS_COMMON  = 9'd365;
  localparam logic [3:0]  MONTH_DEC    = 4'd11;
  localparam logic [3:0]  MONTH_FEB    = 4'd1;

  // Control store. Taken branch goes to target, otherwise to the next step.
  function automatic ucw_t ucode(input pc_t pc);
    ucw_t w;
    w = '{accept: 1'b0, op: OP_NOP, cond: C_ALWAYS, divisor: '0, target: S_LOAD};
    unique case (pc)
      S_LOAD: begin
        w.accept = 1'b1; w.op = OP_LOAD; w.cond = C_NO_INPUT; w.target = S_LOAD;
      end
      S_DIV_SEC: begin
        w.op = OP_DIV; w.cond = C_NEXT; w.divisor = SEC_PER_MIN;
      end
      S_SAVE_SEC: begin
        w.op = OP_SAVE_SEC; w.cond = C_NEXT; w.divisor = SEC_PER_MIN;
      end
      S_DIV_MIN: begin
        w.op = OP_DIV; w.cond = C_NEXT; w.divisor = SEC_PER_MIN;
      end
      S_SAVE_MIN: begin
        w.op = OP_SAVE_MIN; w.cond = C_NEXT; w.divisor = SEC_PER_MIN;
      end
      S_DIV_HR: begin
        w.op = OP_DIV; w.cond = C_NEXT; w.divisor = HR_PER_DAY;
      end
      S_SAVE_HR: begin
        w.op = OP_SAVE_HR; w.cond = C_NEXT; w.divisor = HR_PER_DAY;
      end
      S_YEAR: begin
        w.op = OP_YEAR; w.cond = C_YEAR_MORE; w.target = S_YEAR;
      end
      S_MONTH: begin
        w.op = OP_MONTH; w.cond = C_MONTH_MORE; w.target = S_MONTH;
      end
      S_EMIT: begin
        w.op = OP_EMIT; w.cond = C_OUT_BUSY; w.target = S_EMIT;
      end
      default: begin
        w.op = OP_NOP; w.cond = C_ALWAYS; w.target = S_LOAD;
      end
    endcase
    return w;
  endfunction

  // Days in month m (0 is January).
  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] len;
    unique case (m)
      4'd0, 4'd2, 4'd4, 4'd6, 4'd7, 4'd9, 4'd11: len = 5'd31;
      4'd3, 4'd5, 4'd8, 4'd10:                    len = 5'd30;
      MONTH_FEB:                                  len = leap ? 5'd29 : 5'd28;
      default:                                    len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

`default_nettype wire

// ----- hdl/unix_time_to_calendar_core.sv -----
// ----------------------------------------------------------------------------
// unix_time_to_calendar_core: epoch seconds to UTC date and time
// A microcoded sequencer converts a 32-bit count of seconds since
// 1970-01-01 00:00:00 into year, month, day, hour, minute and second.
// ----------------------------------------------------------------------------
//
//  Channel | Handshake             | Word contents
//  --------+-----------------------+------------------------------------------
//  in      | in_valid / in_ready   | epoch_seconds
//  out     | out_valid / out_ready | cal_year, cal_month, cal_day,
//          |                       | cal_hour, cal_minute, cal_second
//
//  A word passes from acceptance through the three divisions, the year walk
//  over the whole years since 1970 and the month walk over the months before
//  its own; the walks are longest for a date in December 2105. The divisions
//  by 60, 60 and 24 are reciprocal multiplications of two steps each; the
//  rest is the year walk, one year a cycle, and the month walk, one month a
//  cycle. The next word is accepted only after the emit and wrap steps of
//  the previous one. Reset (rst, synchronous) returns the step counter to
//  the load step and empties the result register. A stalled result stays
//  in its register while the next word is accepted and converted; only the
//  final write of the result waits for out_ready.
`default_nettype none

module unix_time_to_calendar_core (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [31:0] epoch_seconds,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [11:0]      cal_year,
  output logic [3:0]       cal_month,
  output logic [4:0]       cal_day,
  output logic [4:0]       cal_hour,
  output logic [5:0]       cal_minute,
  output logic [5:0]       cal_second
);
  import u2cal_pkg::*;

  // Sequencer state.
  pc_t  pc;
  pc_t  pc_next;
  ucw_t cw;
  logic jump;

  // Datapath registers.
  logic [31:0] quo;        // value still to divide, quotient after each save
  logic [63:0] prod;       // value times the reciprocal of the divisor
  logic [5:0]  sec;
  logic [5:0]  min;
  logic [4:0]  hr;
  logic [15:0] days;       // days still to place in a year or month
  logic [11:0] year;
  logic [1:0]  mod4;       // year modulo 4, 100 and 400, kept as counters
  logic [6:0]  mod100;
  logic [8:0]  mod400;
  logic [3:0]  month;      // zero-based

  // Combinational datapath terms.
  logic        by_hr;
  logic [31:0] magic;
  logic [31:0] quot;
  logic [31:0] back;
  logic [31:0] rest;
  logic        leap;
  logic [8:0]  year_len;
  logic        year_more;
  logic [4:0]  mon_len;
  logic        month_more;
  logic        out_busy;

  assign cw = ucode(pc);

  // Division by a constant: multiply by the scaled reciprocal in one step,
  // then take the quotient from the top of the product and the remainder
  // as the value minus quotient times divisor in the next.
  assign by_hr = cw.divisor == HR_PER_DAY;
  assign magic = by_hr ? RECIP_HR : RECIP_MIN;
  assign quot  = by_hr ? {4'd0, prod[63:36]} : {5'd0, prod[63:37]};
  assign back  = by_hr ? (quot << 4) + (quot << 3) : (quot << 6) - (quot << 2);
  assign rest  = quo - back;

  // Gregorian rule: every fourth year, except centuries not divisible by 400.
  assign leap       = (mod4 == 2'd0) && ((mod100 != 7'd0) || (mod400 == 9'd0));
  assign year_len   = leap ? DAYS_LEAP : DAYS_COMMON;
  assign year_more  = days >= {7'd0, year_len};
  assign mon_len    = month_len(month, leap);
  // December absorbs whatever is left, so the month walk stops there.
  assign month_more = (days >= {11'd0, mon_len}) && (month != MONTH_DEC);
  assign out_busy   = out_valid && !out_ready;

  assign in_ready = cw.accept;

  // Branch condition and step counter.
  always_comb begin
    unique case (cw.cond)
      C_NEXT:       jump = 1'b0;
      C_ALWAYS:     jump = 1'b1;
      C_NO_INPUT:   jump = !in_valid;
      C_YEAR_MORE:  jump = year_more;
      C_MONTH_MORE: jump = month_more;
      C_OUT_BUSY:   jump = out_busy;
      default:      jump = 1'b1;
    endcase
    pc_next = jump ? cw.target : pc + 4'd1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= S_LOAD;
    end else begin
      pc <= pc_next;
    end
  end

  // Datapath, driven by the opcode of the current control word.
  always_ff @(posedge clk) begin
    unique case (cw.op)
      OP_LOAD: begin
        if (in_valid) begin
          quo <= epoch_seconds;
        end
      end
      OP_DIV: begin
        prod <= 64'(quo) * 64'(magic);
      end
      OP_SAVE_SEC: begin
        sec <= rest[5:0];
        quo <= quot;
      end
      OP_SAVE_MIN: begin
        min <= rest[5:0];
        quo <= quot;
      end
      OP_SAVE_HR: begin
        hr     <= rest[4:0];
        days   <= quot[15:0];
        year   <= EPOCH_YEAR;
        mod4   <= EPOCH_MOD4;
        mod100 <= EPOCH_MOD100;
        mod400 <= EPOCH_MOD400;
        month  <= '0;
      end
      OP_YEAR: begin
        if (year_more) begin
          days   <= days - {7'd0, year_len};
          year   <= year + 12'd1;
          mod4   <= mod4 + 2'd1;
          mod100 <= (mod100 == MOD100_LAST) ? 7'd0 : mod100 + 7'd1;
          mod400 <= (mod400 == MOD400_LAST) ? 9'd0 : mod400 + 9'd1;
        end
      end
      OP_MONTH: begin
        if (month_more) begin
          days  <= days - {11'd0, mon_len};
          month <= month + 4'd1;
        end
      end
      default: begin
      end
    endcase
  end

  // Result register: filled at the emit step once the previous word is gone.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cw.op == OP_EMIT && !out_busy) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cw.op == OP_EMIT && !out_busy) begin
      cal_year   <= year;
      cal_month  <= month + 4'd1;
      cal_day    <= days[4:0] + 5'd1;
      cal_hour   <= hr;
      cal_minute <= min;
      cal_second <= sec;
    end
  end

  // An accepted word always starts the first division.
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (pc == S_DIV_SEC))
    else $error("accepted word did not start the divider");

  // The day count left after the three divisions fits the day register.
  assert property (@(posedge clk) disable iff (rst)
    (pc == S_SAVE_HR) |-> (quot[31:16] == 16'd0))
    else $error("day count overflows its register");

  // The year walk never passes the last year that 32 bits can reach.
  assert property (@(posedge clk) disable iff (rst)
    (pc == S_YEAR) |-> (year <= 12'd2106))
    else $error("year walk ran past range");

  // The month walk ends with fewer days left than the month holds.
  assert property (@(posedge clk) disable iff (rst)
    (pc == S_MONTH && !month_more) |-> (days < {11'd0, mon_len}))
    else $error("month walk left too many days");

  // While the result register is held at the emit step, the sequencer waits there.
  assert property (@(posedge clk) disable iff (rst)
    (pc == S_EMIT && out_busy) |=> (pc == S_EMIT && out_valid))
    else $error("result overwritten while stalled");

endmodule

`default_nettype wire

// ----- dv/tb_unix_time_to_calendar_core.sv -----
// ----------------------------------------------------------------------------
// tb_unix_time_to_calendar_core: self-checking bench for the epoch converter
// Sends epoch second counts to the converter, predicts each calendar word
// with a behavioral Gregorian conversion and compares every returned word
// field by field, with random idle cycles on both sides.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_unix_time_to_calendar_core;

  // One expected calendar word, at the widths of the output ports.
  typedef struct packed {
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
  } cal_word_t;

  // One pending input word. When wait_drain is set the driver holds it back
  // until every earlier word has come out of the converter.
  typedef struct packed {
    logic [31:0] seconds;
    logic        wait_drain;
  } epoch_item_t;

  localparam int unsigned SECS_PER_DAY  = 86400;
  localparam int unsigned BASE_YEAR     = 1970;
  localparam int unsigned RANDOM_ITEMS  = 880;
  localparam int unsigned DRAIN_EVERY   = 150;
  localparam int unsigned IDLE_PERCENT  = 32;
  // Window of accepted words with no idling on either side.
  localparam int unsigned CALM_FIRST    = 300;
  localparam int unsigned CALM_LAST     = 450;
  // Settle well past the worst conversion.
  localparam int unsigned SETTLE_CYCLES = 300;
  localparam int unsigned LIMIT_CYCLES  = 2_000_000;

  localparam int unsigned MONTH_DAYS [12] = '{31, 28, 31, 30, 31, 30,
                                              31, 31, 30, 31, 30, 31};

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [31:0] epoch_seconds = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [11:0] cal_year;
  logic [3:0]  cal_month;
  logic [4:0]  cal_day;
  logic [4:0]  cal_hour;
  logic [5:0]  cal_minute;
  logic [5:0]  cal_second;

  epoch_item_t epoch_q[$];     // words still to be sent
  cal_word_t   calendar_q[$];  // calendar words expected, oldest first

  int unsigned words_sent   = 0;
  int unsigned words_back   = 0;
  int unsigned fail_cnt     = 0;
  int unsigned leap_days    = 0;
  int unsigned year_ends    = 0;
  int unsigned first_year   = 4095;
  int unsigned last_year    = 0;

  unix_time_to_calendar_core dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .epoch_seconds(epoch_seconds),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .cal_year     (cal_year),
    .cal_month    (cal_month),
    .cal_day      (cal_day),
    .cal_hour     (cal_hour),
    .cal_minute   (cal_minute),
    .cal_second   (cal_second)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
  end

  // Gregorian leap rule: every fourth year, but centuries only when they
  // are divisible by 400.
  function automatic bit gregorian_leap(input int unsigned yr);
    return (yr % 4 == 0) && ((yr % 100 != 0) || (yr % 400 == 0));
  endfunction

  // Expected calendar word for one epoch count. The time of day falls out
  // of successive remainders; the day count is then peeled off whole years
  // from 1970 and whole months from January.
  function automatic cal_word_t to_calendar(input logic [31:0] secs);
    cal_word_t   w;
    int unsigned t;
    int unsigned days;
    int unsigned yr;
    int unsigned mon;
    int unsigned span;
    t        = secs;
    w.second = 6'(t % 60);
    t        = t / 60;
    w.minute = 6'(t % 60);
    t        = t / 60;
    w.hour   = 5'(t % 24);
    days     = t / 24;
    yr       = BASE_YEAR;
    span     = gregorian_leap(yr) ? 366 : 365;
    while (days >= span) begin
      days = days - span;
      yr   = yr + 1;
      span = gregorian_leap(yr) ? 366 : 365;
    end
    // The leftover is always shorter than the year, so December absorbs
    // whatever is left without a further check.
    mon = 0;
    while (mon < 11) begin
      span = MONTH_DAYS[mon];
      if (mon == 1 && gregorian_leap(yr)) begin
        span = 29;
      end
      if (days < span) begin
        break;
      end
      days = days - span;
      mon  = mon + 1;
    end
    w.year  = 12'(yr);
    w.month = 4'(mon + 1);
    w.day   = 5'(days + 1);
    return w;
  endfunction

  function automatic bit calm_window(input int unsigned n);
    return n >= CALM_FIRST && n < CALM_LAST;
  endfunction

  // Random epoch count, biased toward day edges and both ends of the range.
  function automatic logic [31:0] random_epoch();
    int unsigned kind;
    logic [31:0] days;
    kind = $urandom_range(9);
    days = $urandom_range(49709);
    case (kind)
      0, 1, 2, 3: return $urandom;
      4:          return days * SECS_PER_DAY;
      5:          return days * SECS_PER_DAY + SECS_PER_DAY - 1;
      6:          return days * SECS_PER_DAY + $urandom_range(SECS_PER_DAY - 1);
      7:          return $urandom_range(32'hFFFF_FFFF, 32'hFFF0_0000);
      default:    return $urandom_range(400_000);
    endcase
  endfunction

  // Stimulus: a directed list first, then random words. A few words carry
  // the drain mark so the sender sits idle until the converter is empty.
  initial begin
    logic [31:0] directed [$];
    directed = '{32'd0, 32'd1, 32'd59, 32'd60, 32'd3599, 32'd3600, 32'd86399,
                 32'd86400,
                 32'd31535999,   // last second of 1970
                 32'd31536000,   // first second of 1971
                 32'd68255999,   // last second of February in leap year 1972
                 32'd94694399,   // last second of leap year 1972
                 32'd951868799,  // leap day of 2000, a divisible-by-400 century
                 32'd951868800,
                 32'd4107542399, // February 28th of 2100, a non-leap century
                 32'd4107542400,
                 32'h7FFF_FFFF, 32'h8000_0000, 32'h5555_5555, 32'hAAAA_AAAA,
                 32'hFFFF_FFFE, 32'hFFFF_FFFF};
    foreach (directed[i]) begin
      epoch_q.push_back('{seconds: directed[i], wait_drain: (i == 12)});
    end
    for (int unsigned i = 0; i < RANDOM_ITEMS; i++) begin
      epoch_q.push_back('{seconds: random_epoch(), wait_drain: (i % DRAIN_EVERY == 75)});
    end
  end

  // Driver. When a word is taken its expected calendar word is queued, and
  // the next word is either launched at once or held back for an idle cycle
  // or for a drain.
  always @(posedge clk) begin : drive_proc
    epoch_item_t nxt;
    bit          taken;
    bit          launch;
    bit          busy;
    taken  = in_valid && in_ready;
    launch = 1'b0;
    if (rst) begin
      in_valid      <= 1'b0;
      epoch_seconds <= '0;
    end else begin
      if (taken) begin
        calendar_q.push_back(to_calendar(epoch_seconds));
        words_sent <= words_sent + 1;
      end
      if ((!in_valid || taken) && epoch_q.size() != 0) begin
        busy = taken || (words_sent != words_back);
        if (!(epoch_q[0].wait_drain && busy) &&
            (calm_window(words_sent) || $urandom_range(99) >= IDLE_PERCENT)) begin
          nxt    = epoch_q.pop_front();
          launch = 1'b1;
        end
      end
      if (launch) begin
        in_valid      <= 1'b1;
        epoch_seconds <= nxt.seconds;
      end else if (taken) begin
        in_valid <= 1'b0;
      end
    end
  end

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      fail_cnt++;
    end
  endtask

  // Monitor. Every returned calendar word is matched against the oldest
  // expectation; out_ready stalls at random outside the calm window.
  always @(posedge clk) begin : check_proc
    cal_word_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        words_back <= words_back + 1;
        if (calendar_q.size() == 0) begin
          $error("calendar word %0d-%0d-%0d arrived with none expected",
                 cal_year, cal_month, cal_day);
          fail_cnt++;
        end else begin
          want = calendar_q.pop_front();
          check_field("cal_year",   32'(want.year),   32'(cal_year));
          check_field("cal_month",  32'(want.month),  32'(cal_month));
          check_field("cal_day",    32'(want.day),    32'(cal_day));
          check_field("cal_hour",   32'(want.hour),   32'(cal_hour));
          check_field("cal_minute", 32'(want.minute), 32'(cal_minute));
          check_field("cal_second", 32'(want.second), 32'(cal_second));
          if (want.month == 2 && want.day == 29) begin
            leap_days++;
          end
          if (want.month == 12 && want.day == 31) begin
            year_ends++;
          end
          if (want.year < first_year) begin
            first_year = 32'(want.year);
          end
          if (want.year > last_year) begin
            last_year = 32'(want.year);
          end
        end
      end
      out_ready <= calm_window(words_back) || $urandom_range(99) >= IDLE_PERCENT;
    end
  end

  // End of run. Sampling on the falling edge keeps the drain test clear of
  // the updates made at the rising edge.
  initial begin
    @(negedge clk);
    while (rst || epoch_q.size() != 0 || in_valid || words_sent != words_back) begin
      @(negedge clk);
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (calendar_q.size() != 0) begin
      $error("%0d calendar words never arrived", calendar_q.size());
      fail_cnt++;
    end
    $display("Converted %0d epoch words into dates from %0d to %0d,", words_back,
             first_year, last_year);
    $display("among them %0d leap days and %0d year-end days; %0d failures.",
             leap_days, year_ends, fail_cnt);
    if (fail_cnt == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #(4 * LIMIT_CYCLES);
    $error("run did not finish within %0d cycles", LIMIT_CYCLES);
    $display("Regression FAIL");
    $finish;
  end

endmodule

`default_nettype wire

// ----- unix_time_to_calendar_core.f -----
hdl/u2cal_pkg.sv
hdl/unix_time_to_calendar_core.sv
dv/tb_unix_time_to_calendar_core.sv
